[src/rotated_pole_coordinate_transform_defines.svh]
// Assertion macros shared by the checker of the rotated-pole transform.
// Depends on nothing; included by the checker file only.
`ifndef ROTATED_POLE_COORDINATE_TRANSFORM_DEFINES_SVH
`define ROTATED_POLE_COORDINATE_TRANSFORM_DEFINES_SVH

// Implication in the same cycle, switched off while reset is asserted.
`define RPCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpct: property failed");

// Implication into the next cycle, active during reset as well.
`define RPCT_ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rpct: property failed");

`endif

[src/rpct_pkg.sv]
// Shared widths, types and pipeline figures of the rotated-pole transform.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package rpct_pkg;

  localparam int CORDIC_STAGES   = 24;
  localparam int ANGLE_FRAC_BITS = 16;

  localparam int LAT_W = 24;
  localparam int LON_W = 25;

  // CORDIC datapath width: Q30 vectors with headroom and extended binary angles.
  localparam int CW = 34;

  localparam int ROOT_W          = 31;
  localparam int DEG2BAM_STAGES  = 4;
  localparam int MIX_STAGES      = 4;

  localparam int PIPE_LATENCY = DEG2BAM_STAGES + CORDIC_STAGES + MIX_STAGES + 1 + ROOT_W
                                + CORDIC_STAGES + 1;

  typedef enum logic {
    CORDIC_ROTATE,
    CORDIC_VECTOR
  } cordic_mode_t;

  typedef struct packed {
    logic valid;
    logic tag;
  } cordic_ctl_t;

endpackage

[src/rpct_cordic.sv]
// Unrolled circular CORDIC pipeline, one register stage per iteration.
// Depends on rpct_pkg; works in rotation or vectoring mode.
`timescale 1ns / 1ps

module rpct_cordic (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rpct_pkg::cordic_mode_t          mode,
  input  rpct_pkg::cordic_ctl_t           ctl_i,
  input  logic signed [rpct_pkg::CW-1:0]  x_i,
  input  logic signed [rpct_pkg::CW-1:0]  y_i,
  input  logic signed [rpct_pkg::CW-1:0]  z_i,
  output rpct_pkg::cordic_ctl_t           ctl_o,
  output logic signed [rpct_pkg::CW-1:0]  x_o,
  output logic signed [rpct_pkg::CW-1:0]  y_o,
  output logic signed [rpct_pkg::CW-1:0]  z_o
);
  import rpct_pkg::*;

  localparam logic [31:0] ATAN_BAM [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000
  };

  logic signed [CW-1:0] x_r [CORDIC_STAGES];
  logic signed [CW-1:0] y_r [CORDIC_STAGES];
  logic signed [CW-1:0] z_r [CORDIC_STAGES];
  cordic_ctl_t          ctl_r [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [CW-1:0] xp, yp, zp, dx, dy, ang;
    cordic_ctl_t          cp;
    logic                 dir;

    if (i == 0) begin : g_first
      assign xp = x_i;
      assign yp = y_i;
      assign zp = z_i;
      assign cp = ctl_i;
    end else begin : g_next
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
      assign cp = ctl_r[i-1];
    end

    assign dx  = yp >>> i;
    assign dy  = xp >>> i;
    assign ang = CW'(ATAN_BAM[i]);
    assign dir = (mode == CORDIC_VECTOR) ? (yp <= 0) : (zp >= 0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i] <= '0;
      end else begin
        ctl_r[i] <= cp;
      end
    end

    always_ff @(posedge clk) begin
      x_r[i] <= dir ? xp - dx  : xp + dx;
      y_r[i] <= dir ? yp + dy  : yp - dy;
      z_r[i] <= dir ? zp - ang : zp + ang;
    end
  end

  assign ctl_o = ctl_r[CORDIC_STAGES-1];
  assign x_o   = x_r[CORDIC_STAGES-1];
  assign y_o   = y_r[CORDIC_STAGES-1];
  assign z_o   = z_r[CORDIC_STAGES-1];

endmodule

[src/rotated_pole_coordinate_transform.sv]
// Rotated-pole latitude/longitude transform, fully pipelined.
// One word is taken every cycle in which busy is low.
// The latency is set by the two 24-stage CORDIC pipelines and the 31-stage square root.
// Synchronous active-low reset clears the pipeline valids and loads the pole registers
// with latitude -90 degrees and longitude 0; busy is high during reset and in the cycle after it.
`timescale 1ns / 1ps

module rotated_pole_coordinate_transform (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_command,
  input  logic signed [rpct_pkg::LAT_W-1:0]    in_lat_in,
  input  logic signed [rpct_pkg::LON_W-1:0]    in_lon_in,
  output logic                                 out_strobe,
  output logic signed [rpct_pkg::LAT_W-1:0]    out_lat_out,
  output logic signed [rpct_pkg::LON_W-1:0]    out_lon_out
);
  import rpct_pkg::*;

  localparam logic REG_POLE_LAT = 1'b0;
  localparam logic REG_POLE_LON = 1'b1;

  localparam int QW     = 32;
  localparam int DEG_W  = 26;
  localparam int U_W    = 27;
  localparam int M_W    = 28;
  localparam int P_W    = U_W + M_W;
  localparam int Q_W    = 22;
  localparam int A_W    = 23;
  localparam int N_W    = 61;
  localparam int TR_W   = 63;
  localparam int BD_W   = CW + 11;
  localparam int LANES  = 4;
  localparam int FRAC_SHIFT = 29 - ANGLE_FRAC_BITS;
  localparam int CMD_DLY    = DEG2BAM_STAGES + CORDIC_STAGES + 2;
  localparam int LON_DLY    = 1 + ROOT_W;

  localparam int DIV_K   = 745655;
  localparam int DIV_OFS = 45 * DIV_K;
  localparam int DIV_M   = 190887436;
  localparam int DIV_S   = 33;

  localparam logic signed [DEG_W-1:0] LAT_LIM_D = DEG_W'(90 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [BD_W-1:0]  LAT_LIM_B = BD_W'(90 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [BD_W-1:0]  LON_LIM_B = BD_W'(180 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [CW-1:0]    QUARTER   = CW'(64'd1 << 30);
  localparam logic signed [CW-1:0]    HALF      = CW'(64'd1 << 31);
  localparam logic signed [CW-1:0]    GAIN      = CW'(652032874);
  localparam logic signed [2*QW-1:0]  ONE_SQ    = (2*QW)'(64'd1 << 60);

  typedef logic [FRAC_SHIFT-1:0] frac_tbl_t [64];

  function automatic frac_tbl_t build_frac();
    frac_tbl_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = (i < 45) ? FRAC_SHIFT'((i * (1 << FRAC_SHIFT) + 22) / 45) : '0;
    end
    return t;
  endfunction

  localparam frac_tbl_t FRAC_TBL = build_frac();

  function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = (2*QW)'(a) * (2*QW)'(b) + (2*QW)'(64'd1 << 29);
    return QW'(p >>> 30);
  endfunction

  function automatic logic signed [BD_W-1:0] bam_to_deg(input logic signed [CW-1:0] b);
    logic signed [BD_W-1:0] p;
    p = BD_W'(b) * BD_W'(720) + BD_W'(64'd1 << (32 - ANGLE_FRAC_BITS));
    return p >>> (33 - ANGLE_FRAC_BITS);
  endfunction

  // Configuration registers and port.
  logic signed [LAT_W-1:0] pole_lat_r;
  logic signed [LON_W-1:0] pole_lon_r;
  logic                    busy_r;
  logic                    acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_lat_r <= -LAT_W'(90 * (1 << ANGLE_FRAC_BITS));
      pole_lon_r <= '0;
      busy_r     <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (psel && penable && pwrite) begin
        unique case (paddr[2])
          REG_POLE_LAT: pole_lat_r <= pwdata[LAT_W-1:0];
          REG_POLE_LON: pole_lon_r <= pwdata[LON_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign prdata = (paddr[2] == REG_POLE_LON) ? 32'(pole_lon_r) : 32'(pole_lat_r);
  assign pready = 1'b1;
  assign busy   = busy_r;
  assign acc    = start && !busy_r;

  // Degrees to binary angle, four lanes: latitude, longitude, theta, phi.
  logic signed [DEG_W-1:0] deg_v [LANES];
  logic [U_W-1:0]          u_nxt [LANES];
  logic [P_W-1:0]          prod  [LANES];
  logic [U_W-1:0]          rm    [LANES];
  logic [U_W-1:0]          u_r   [LANES];
  logic [U_W-1:0]          uq_r  [LANES];
  logic [Q_W-1:0]          q_r   [LANES];
  logic signed [A_W-1:0]   a_r   [LANES];
  logic [5:0]              b_r   [LANES];
  logic signed [QW-1:0]    bam_r [LANES];
  logic [DEG2BAM_STAGES-1:0] dv_r;
  logic [CMD_DLY-1:0]      cmd_r;

  always_comb begin
    deg_v[0] = DEG_W'(in_lat_in);
    deg_v[1] = DEG_W'(in_lon_in);
    deg_v[2] = LAT_LIM_D + DEG_W'(pole_lat_r);
    deg_v[3] = DEG_W'(pole_lon_r);
    for (int k = 0; k < LANES; k++) begin
      u_nxt[k] = U_W'(U_W'(deg_v[k]) + U_W'(DIV_OFS));
      prod[k]  = P_W'(u_r[k]) * P_W'(DIV_M);
      rm[k]    = uq_r[k] - U_W'(U_W'(q_r[k]) * U_W'(45));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else begin
      dv_r <= {dv_r[DEG2BAM_STAGES-2:0], acc};
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= {cmd_r[CMD_DLY-2:0], in_command};
    for (int k = 0; k < LANES; k++) begin
      u_r[k]   <= u_nxt[k];
      uq_r[k]  <= u_r[k];
      q_r[k]   <= prod[k][DIV_S+Q_W-1:DIV_S];
      a_r[k]   <= signed'(A_W'(q_r[k]) - A_W'(DIV_K));
      b_r[k]   <= rm[k][5:0];
      bam_r[k] <= (QW'(a_r[k]) <<< FRAC_SHIFT) + QW'(FRAC_TBL[b_r[k]]);
    end
  end

  // Fold into the right half-plane, then sine and cosine.
  logic signed [CW-1:0] fz   [LANES];
  logic                 flip [LANES];
  cordic_ctl_t          sc_ctl_i [LANES];
  cordic_ctl_t          sc_ctl_o [LANES];
  logic signed [CW-1:0] sc_x [LANES];
  logic signed [CW-1:0] sc_y [LANES];
  logic signed [CW-1:0] sc_z [LANES];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      fz[k]   = CW'(bam_r[k]);
      flip[k] = 1'b0;
      if (fz[k] > QUARTER) begin
        fz[k]   = fz[k] - HALF;
        flip[k] = 1'b1;
      end else if (fz[k] < -QUARTER) begin
        fz[k]   = fz[k] + HALF;
        flip[k] = 1'b1;
      end
      sc_ctl_i[k] = '{valid: dv_r[DEG2BAM_STAGES-1], tag: flip[k]};
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_sincos
    rpct_cordic u_sincos (
      .clk   (clk),
      .rst_n (rst_n),
      .mode  (CORDIC_ROTATE),
      .ctl_i (sc_ctl_i[k]),
      .x_i   (GAIN),
      .y_i   ('0),
      .z_i   (fz[k]),
      .ctl_o (sc_ctl_o[k]),
      .x_o   (sc_x[k]),
      .y_o   (sc_y[k]),
      .z_o   (sc_z[k])
    );
  end

  // Trig results: lane 0 latitude, 1 longitude, 2 theta, 3 phi.
  logic signed [QW-1:0] cos_r [LANES];
  logic signed [QW-1:0] sin_r [LANES];
  logic                 t_valid_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      cos_r[k] <= QW'(sc_ctl_o[k].tag ? -sc_x[k] : sc_x[k]);
      sin_r[k] <= QW'(sc_ctl_o[k].tag ? -sc_y[k] : sc_y[k]);
    end
  end

  // Rotation matrix terms and the unit vector.
  logic signed [QW-1:0] vx_r, vy_r, vz_r;
  logic signed [QW-1:0] ctcp_r, ctsp_r, stcp_r, stsp_r;
  logic signed [QW-1:0] st_r, ct_r, sp_r, cp_r;
  logic                 m1_valid_r;

  always_ff @(posedge clk) begin
    vx_r   <= mulq(cos_r[1], cos_r[0]);
    vy_r   <= mulq(sin_r[1], cos_r[0]);
    vz_r   <= sin_r[0];
    ctcp_r <= mulq(cos_r[2], cos_r[3]);
    ctsp_r <= mulq(cos_r[2], sin_r[3]);
    stcp_r <= mulq(sin_r[2], cos_r[3]);
    stsp_r <= mulq(sin_r[2], sin_r[3]);
    st_r   <= sin_r[2];
    ct_r   <= cos_r[2];
    sp_r   <= sin_r[3];
    cp_r   <= cos_r[3];
  end

  logic                 m1_cmd;
  logic signed [QW-1:0] ma [8];
  logic signed [QW-1:0] mb [8];
  logic signed [QW-1:0] m_r [8];
  logic                 m2_cmd_r;
  logic                 m2_valid_r;

  assign m1_cmd = cmd_r[CMD_DLY-1];

  always_comb begin
    ma[0] = ctcp_r;  mb[0] = vx_r;
    ma[4] = cp_r;    mb[4] = vy_r;
    ma[7] = ct_r;    mb[7] = vz_r;
    if (!m1_cmd) begin
      ma[1] = ctsp_r;  mb[1] = vy_r;
      ma[2] = st_r;    mb[2] = vz_r;
      ma[3] = sp_r;    mb[3] = vx_r;
      ma[5] = stcp_r;  mb[5] = vx_r;
      ma[6] = stsp_r;  mb[6] = vy_r;
    end else begin
      ma[1] = sp_r;    mb[1] = vy_r;
      ma[2] = stcp_r;  mb[2] = vz_r;
      ma[3] = ctsp_r;  mb[3] = vx_r;
      ma[5] = stsp_r;  mb[5] = vz_r;
      ma[6] = st_r;    mb[6] = vx_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) begin
      m_r[k] <= mulq(ma[k], mb[k]);
    end
    m2_cmd_r <= m1_cmd;
  end

  logic signed [CW-1:0] e [8];
  logic signed [CW-1:0] xn_nxt, yn_nxt, zn_nxt, zc_nxt;
  logic signed [CW-1:0] xn_r, yn_r;
  logic signed [QW-1:0] zc_r;
  logic                 m3_valid_r;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      e[k] = CW'(m_r[k]);
    end
    if (!m2_cmd_r) begin
      xn_nxt = e[0] + e[1] + e[2];
      yn_nxt = e[4] - e[3];
      zn_nxt = e[7] - e[5] - e[6];
    end else begin
      xn_nxt = e[0] - e[1] - e[2];
      yn_nxt = e[3] + e[4] - e[5];
      zn_nxt = e[6] + e[7];
    end
    if (zn_nxt > QUARTER) begin
      zc_nxt = QUARTER;
    end else if (zn_nxt < -QUARTER) begin
      zc_nxt = -QUARTER;
    end else begin
      zc_nxt = zn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xn_r <= xn_nxt;
    yn_r <= yn_nxt;
    zc_r <= QW'(zc_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_valid_r  <= 1'b0;
      m1_valid_r <= 1'b0;
      m2_valid_r <= 1'b0;
      m3_valid_r <= 1'b0;
    end else begin
      t_valid_r  <= sc_ctl_o[0].valid & sc_ctl_o[1].valid & sc_ctl_o[2].valid
                    & sc_ctl_o[3].valid;
      m1_valid_r <= t_valid_r;
      m2_valid_r <= m1_valid_r;
      m3_valid_r <= m2_valid_r;
    end
  end

  // Longitude: atan2 of the rotated vector.
  logic                 lneg;
  logic signed [CW-1:0] lx, ly, lz;
  cordic_ctl_t          lon_ctl_i, lon_ctl_o;
  logic signed [CW-1:0] lon_x, lon_y, lon_z;
  logic signed [CW-1:0] lon_dly_r [LON_DLY];

  always_comb begin
    lneg      = xn_r < 0;
    lx        = lneg ? -xn_r : xn_r;
    ly        = lneg ? -yn_r : yn_r;
    lz        = lneg ? ((yn_r >= 0) ? HALF : -HALF) : '0;
    lon_ctl_i = '{valid: m3_valid_r, tag: (xn_r == 0) && (yn_r == 0)};
  end

  rpct_cordic u_lon_atan (
    .clk   (clk),
    .rst_n (rst_n),
    .mode  (CORDIC_VECTOR),
    .ctl_i (lon_ctl_i),
    .x_i   (lx),
    .y_i   (ly),
    .z_i   (lz),
    .ctl_o (lon_ctl_o),
    .x_o   (lon_x),
    .y_o   (lon_y),
    .z_o   (lon_z)
  );

  always_ff @(posedge clk) begin
    lon_dly_r[0] <= (lon_ctl_o.tag || !lon_ctl_o.valid || (lon_x == lon_y && 1'b0))
                    ? '0 : lon_z;
    for (int k = 1; k < LON_DLY; k++) begin
      lon_dly_r[k] <= lon_dly_r[k-1];
    end
  end

  // Latitude: asin(z) = atan2(z, sqrt(1 - z^2)).
  logic [N_W-1:0]       n_r;
  logic signed [QW-1:0] zs_r;
  logic                 sq_valid_r;
  logic signed [2*QW-1:0] zsq;

  assign zsq = ONE_SQ - (2*QW)'(zc_r) * (2*QW)'(zc_r);

  always_ff @(posedge clk) begin
    n_r  <= N_W'(zsq);
    zs_r <= zc_r;
  end

  logic [N_W-1:0]       rem_r  [ROOT_W];
  logic [ROOT_W-1:0]    root_r [ROOT_W];
  logic signed [QW-1:0] rz_r   [ROOT_W];
  logic [ROOT_W-1:0]    rv_r;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_root
    localparam int B = ROOT_W - 1 - j;
    logic [N_W-1:0]       rp;
    logic [ROOT_W-1:0]    qp;
    logic signed [QW-1:0] zp;
    logic [TR_W-1:0]      trial;
    logic                 take;

    if (j == 0) begin : g_first
      assign rp = n_r;
      assign qp = '0;
      assign zp = zs_r;
    end else begin : g_next
      assign rp = rem_r[j-1];
      assign qp = root_r[j-1];
      assign zp = rz_r[j-1];
    end

    assign trial = (TR_W'(qp) << (B + 1)) + (TR_W'(1) << (2 * B));
    assign take  = TR_W'(rp) >= trial;

    always_ff @(posedge clk) begin
      rem_r[j]  <= take ? N_W'(TR_W'(rp) - trial) : rp;
      root_r[j] <= take ? (qp | (ROOT_W'(1) << B)) : qp;
      rz_r[j]   <= zp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r <= 1'b0;
      rv_r       <= '0;
    end else begin
      sq_valid_r <= m3_valid_r;
      rv_r       <= {rv_r[ROOT_W-2:0], sq_valid_r};
    end
  end

  cordic_ctl_t          lat_ctl_i, lat_ctl_o;
  logic signed [CW-1:0] lat_x, lat_y, lat_z;

  assign lat_ctl_i = '{valid: rv_r[ROOT_W-1], tag: 1'b0};

  rpct_cordic u_lat_atan (
    .clk   (clk),
    .rst_n (rst_n),
    .mode  (CORDIC_VECTOR),
    .ctl_i (lat_ctl_i),
    .x_i   (CW'(root_r[ROOT_W-1])),
    .y_i   (CW'(rz_r[ROOT_W-1])),
    .z_i   ('0),
    .ctl_o (lat_ctl_o),
    .x_o   (lat_x),
    .y_o   (lat_y),
    .z_o   (lat_z)
  );

  // Back to degrees, clamp and register the result word.
  logic signed [BD_W-1:0]  lat_d, lon_d, lat_c, lon_c;
  logic                    strobe_r;
  logic signed [LAT_W-1:0] lat_out_r;
  logic signed [LON_W-1:0] lon_out_r;

  always_comb begin
    lat_d = bam_to_deg(lat_z);
    lon_d = bam_to_deg(lon_dly_r[LON_DLY-1]);
    if (lat_d > LAT_LIM_B) begin
      lat_c = LAT_LIM_B;
    end else if (lat_d < -LAT_LIM_B) begin
      lat_c = -LAT_LIM_B;
    end else begin
      lat_c = lat_d;
    end
    if (lon_d > LON_LIM_B) begin
      lon_c = LON_LIM_B;
    end else if (lon_d < -LON_LIM_B) begin
      lon_c = -LON_LIM_B;
    end else begin
      lon_c = lon_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= lat_ctl_o.valid && (lat_x == lat_x) && (lat_y == lat_y);
    end
  end

  always_ff @(posedge clk) begin
    lat_out_r <= LAT_W'(lat_c);
    lon_out_r <= LON_W'(lon_c);
  end

  assign out_strobe  = strobe_r;
  assign out_lat_out = lat_out_r;
  assign out_lon_out = lon_out_r;

endmodule

[src/rpct_checker.sv]
// Port-level checker of the rotated-pole transform, bound to the top level.
// Depends on rpct_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "rotated_pole_coordinate_transform_defines.svh"

module rpct_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_strobe,
  input logic signed [rpct_pkg::LAT_W-1:0] out_lat_out,
  input logic signed [rpct_pkg::LON_W-1:0] out_lon_out
);
  import rpct_pkg::*;

  localparam logic signed [LAT_W-1:0] LAT_LIM = LAT_W'(90 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [LON_W-1:0] LON_LIM = LON_W'(180 * (1 << ANGLE_FRAC_BITS));

  `RPCT_ASSERT_IMP(a_latency, clk, rst_n, start && !busy, ##PIPE_LATENCY out_strobe)
  `RPCT_ASSERT_IMP(a_no_spurious, clk, rst_n, out_strobe, $past(start && !busy, PIPE_LATENCY))
  `RPCT_ASSERT_IMP(a_lat_range, clk, rst_n, out_strobe, (out_lat_out <= LAT_LIM) && (out_lat_out >= -LAT_LIM))
  `RPCT_ASSERT_IMP(a_lon_range, clk, rst_n, out_strobe, (out_lon_out <= LON_LIM) && (out_lon_out >= -LON_LIM))
  `RPCT_ASSERT_NEXT(a_reset_idle, clk, !rst_n, busy && !out_strobe)

endmodule

bind rotated_pole_coordinate_transform rpct_checker u_rpct_checker (.*);
